// File: rtl/core/pcm_out_descriptor_dma_engine_macros.svh
// assertion helpers for the pcm-out dma engine
`ifndef PCM_OUT_DESCRIPTOR_DMA_ENGINE_MACROS_SVH
`define PCM_OUT_DESCRIPTOR_DMA_ENGINE_MACROS_SVH

// same-cycle implication, sampled on clk_i, quiet in reset
`define PCMDMA_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, sampled on clk_i, quiet in reset
`define PCMDMA_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: rtl/core/pcmdma_pkg.sv
`default_nettype none

package pcmdma_pkg;

  typedef enum logic [1:0] {
    OpRead  = 2'd0,
    OpWrite = 2'd1,
    OpLoad  = 2'd2,
    OpTick  = 2'd3
  } opcode_e;

  // register box offsets
  localparam logic [3:0] OfsBase   = 4'h0;
  localparam logic [3:0] OfsCur    = 4'h4;
  localparam logic [3:0] OfsLast   = 4'h5;
  localparam logic [3:0] OfsStatus = 4'h6;
  localparam logic [3:0] OfsLeft   = 4'h8;
  localparam logic [3:0] OfsCtrl   = 4'hB;

  // control register bits
  localparam int unsigned CtrlRunBit   = 0;
  localparam int unsigned CtrlResetBit = 1;

  typedef struct packed {
    logic [31:0] addr;
    logic [15:0] len;
  } entry_t;

endpackage

`default_nettype wire

// File: rtl/core/pcm_out_descriptor_dma_engine.sv
`default_nettype none

// channel  valid        stall        payload
// in       in_valid_i   in_stall_o   opcode_i, reg_offset_i, write_data_i,
//                                    desc_index_i, desc_address_i, desc_samples_i
// out      out_valid_o  out_stall_i  read_data_o, fetch_valid_o, fetch_address_o,
//                                    engine_halted_o, buffer_done_o
//
// one item per cycle while the result is not stalled; each item passes the input register, then the result register
// the ring store is read every cycle at the current entry and the one after it
// rst_ni clears control state at once; ring entries hold nothing until loaded
// a stalled result holds; a new item is still taken while the input register is free

module pcm_out_descriptor_dma_engine #(
  parameter int unsigned RING_ENTRIES = 32
) (
  input  wire                   clk_i,
  input  wire                   rst_ni,
  input  wire                   in_valid_i,
  output logic                  in_stall_o,
  input  wire  [1:0]            opcode_i,
  input  wire  [3:0]            reg_offset_i,
  input  wire  [31:0]           write_data_i,
  input  wire  [4:0]            desc_index_i,
  input  wire  [31:0]           desc_address_i,
  input  wire  [15:0]           desc_samples_i,
  output logic                  out_valid_o,
  input  wire                   out_stall_i,
  output logic [31:0]           read_data_o,
  output logic                  fetch_valid_o,
  output logic [31:0]           fetch_address_o,
  output logic                  engine_halted_o,
  output logic                  buffer_done_o
);
  import pcmdma_pkg::*;

  localparam int unsigned IdxW     = $clog2(RING_ENTRIES);
  localparam int unsigned RecipMul = (65536 + RING_ENTRIES - 1) / RING_ENTRIES;
  localparam logic [IdxW-1:0] LastIdx = IdxW'(RING_ENTRIES - 1);

  // reduce an 8-bit value modulo the ring size by reciprocal multiply
  function automatic logic [IdxW-1:0] ring_mod(input logic [7:0] v);
    logic [23:0] prod;
    logic [16:0] back;
    logic [8:0]  rem;
    prod = 24'(v) * 24'(RecipMul);
    back = 17'(prod[23:16]) * 17'(RING_ENTRIES);
    rem  = 9'(v) - back[8:0];
    return rem[IdxW-1:0];
  endfunction

  function automatic logic [IdxW-1:0] ring_inc(input logic [IdxW-1:0] i);
    return (i == LastIdx) ? '0 : i + 1'b1;
  endfunction

  // input register
  logic        s1_valid_q, s1_valid_d;
  opcode_e     s1_op_q;
  logic [3:0]  s1_ofs_q;
  logic [31:0] s1_wdata_q;
  logic [4:0]  s1_didx_q;
  logic [31:0] s1_daddr_q;
  logic [15:0] s1_dlen_q;

  // result register
  logic        out_valid_q;
  logic [31:0] out_rdata_q;
  logic        out_fetch_q;
  logic [31:0] out_addr_q;
  logic        out_halted_q;
  logic        out_done_q;

  // channel state
  logic [31:0]     base_q, base_d;
  logic [IdxW-1:0] cur_q, cur_d;
  logic [IdxW-1:0] lvi_q, lvi_d;
  logic [15:0]     left_q, left_d;
  logic            left_mem_q, left_mem_d;
  logic            halted_q, halted_d;
  logic            running_q, running_d;
  logic            loaded_q, loaded_d;

  // ring store
  entry_t          ring_mem [RING_ENTRIES];
  entry_t          ent_a_q, ent_b_q;
  entry_t          wr_entry;
  logic            mem_we;
  logic [IdxW-1:0] mem_widx;
  logic [IdxW-1:0] nxt_d;

  logic            advance, fire, in_accept, chan_rst;
  logic [15:0]     left_eff;

  // tick datapath
  logic            tk_go, tk_use_b;
  logic [IdxW-1:0] tk_cur;
  logic [15:0]     tk_left, tk_left_dec;
  entry_t          tk_ent;
  logic [31:0]     tk_diff;

  logic [31:0]     res_rdata;
  logic            res_fetch;
  logic [31:0]     res_addr;
  logic            res_done;

  assign advance    = !out_valid_q || !out_stall_i;
  assign fire       = s1_valid_q && advance;
  assign in_stall_o = s1_valid_q && !advance;
  assign in_accept  = in_valid_i && !in_stall_o;
  assign left_eff   = left_mem_q ? ent_a_q.len : left_q;
  assign mem_widx   = ring_mod({3'b000, s1_didx_q});
  assign wr_entry   = '{addr: s1_daddr_q, len: s1_dlen_q};
  assign nxt_d      = ring_inc(cur_d);
  assign tk_diff    = {16'h0000, tk_ent.len} - {16'h0000, tk_left};
  assign tk_left_dec = tk_left - 16'd1;
  assign chan_rst   = fire && (s1_op_q == OpWrite) && (s1_ofs_q == OfsCtrl)
                      && s1_wdata_q[CtrlResetBit];

  always_comb begin
    base_d     = base_q;
    cur_d      = cur_q;
    lvi_d      = lvi_q;
    left_d     = left_eff;
    left_mem_d = 1'b0;
    halted_d   = halted_q;
    running_d  = running_q;
    loaded_d   = loaded_q;
    mem_we     = 1'b0;
    res_rdata  = '0;
    res_fetch  = 1'b0;
    res_addr   = '0;
    res_done   = 1'b0;
    tk_go      = 1'b0;
    tk_use_b   = 1'b0;
    tk_cur     = cur_q;
    tk_left    = left_eff;
    tk_ent     = ent_a_q;
    if (fire) begin
      unique case (s1_op_q)
        OpRead: begin
          case (s1_ofs_q)
            OfsBase:   res_rdata = base_q;
            OfsCur:    res_rdata = 32'(cur_q);
            OfsLast:   res_rdata = 32'(lvi_q);
            OfsStatus: res_rdata = {31'h0, halted_q};
            OfsLeft:   res_rdata = {16'h0000, left_eff};
            OfsCtrl:   res_rdata = {31'h0, running_q};
            default:   res_rdata = '0;
          endcase
        end
        OpWrite: begin
          if (s1_ofs_q == OfsBase) begin
            base_d = {s1_wdata_q[31:3], 3'b000};
          end else if (s1_ofs_q == OfsLast) begin
            lvi_d = ring_mod(s1_wdata_q[7:0]);
          end else if (s1_ofs_q == OfsCtrl) begin
            if (s1_wdata_q[CtrlResetBit]) begin
              base_d    = '0;
              cur_d     = '0;
              lvi_d     = '0;
              left_d    = '0;
              halted_d  = 1'b1;
              running_d = 1'b0;
              loaded_d  = 1'b0;
            end else begin
              running_d = s1_wdata_q[CtrlRunBit];
            end
          end
        end
        OpLoad: begin
          mem_we = 1'b1;
        end
        OpTick: begin
          if (running_q) begin
            tk_go = 1'b1;
            if (halted_q) begin
              if (!loaded_q) begin
                tk_left  = ent_a_q.len;
                halted_d = 1'b0;
                loaded_d = 1'b1;
              end else if (cur_q != lvi_q) begin
                tk_cur   = ring_inc(cur_q);
                tk_use_b = 1'b1;
                tk_left  = ent_b_q.len;
                halted_d = 1'b0;
              end else begin
                tk_go = 1'b0;
              end
            end
            tk_ent = tk_use_b ? ent_b_q : ent_a_q;
            if (tk_go) begin
              cur_d  = tk_cur;
              left_d = tk_left;
              if (tk_left != 16'd0) begin
                res_fetch = 1'b1;
                res_addr  = tk_ent.addr + {tk_diff[30:0], 1'b0};
                left_d    = tk_left_dec;
              end
              if (tk_left == 16'd0 || tk_left_dec == 16'd0) begin
                res_done = 1'b1;
                left_d   = '0;
                if (tk_cur == lvi_q) begin
                  halted_d = 1'b1;
                end else begin
                  // next length comes from the store in the following cycle
                  cur_d      = ring_inc(tk_cur);
                  left_mem_d = 1'b1;
                end
              end
            end
          end
        end
        default: ;
      endcase
    end
  end

  always_comb begin
    s1_valid_d = s1_valid_q;
    if (in_accept) begin
      s1_valid_d = 1'b1;
    end else if (fire) begin
      s1_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      base_q      <= '0;
      cur_q       <= '0;
      lvi_q       <= '0;
      left_q      <= '0;
      left_mem_q  <= 1'b0;
      halted_q    <= 1'b1;
      running_q   <= 1'b0;
      loaded_q    <= 1'b0;
    end else begin
      s1_valid_q <= s1_valid_d;
      if (advance) begin
        out_valid_q <= fire;
      end
      base_q     <= base_d;
      cur_q      <= cur_d;
      lvi_q      <= lvi_d;
      left_q     <= left_d;
      left_mem_q <= left_mem_d;
      halted_q   <= halted_d;
      running_q  <= running_d;
      loaded_q   <= loaded_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      s1_op_q    <= opcode_e'(opcode_i);
      s1_ofs_q   <= reg_offset_i;
      s1_wdata_q <= write_data_i;
      s1_didx_q  <= desc_index_i;
      s1_daddr_q <= desc_address_i;
      s1_dlen_q  <= desc_samples_i;
    end
    if (fire) begin
      out_rdata_q  <= res_rdata;
      out_fetch_q  <= res_fetch;
      out_addr_q   <= res_addr;
      out_halted_q <= halted_d;
      out_done_q   <= res_done;
    end
  end

  // ring store, one write port and two registered read ports with write bypass
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      ring_mem[mem_widx] <= wr_entry;
    end
    ent_a_q <= (mem_we && mem_widx == cur_d) ? wr_entry : ring_mem[cur_d];
    ent_b_q <= (mem_we && mem_widx == nxt_d) ? wr_entry : ring_mem[nxt_d];
  end

  assign out_valid_o     = out_valid_q;
  assign read_data_o     = out_rdata_q;
  assign fetch_valid_o   = out_fetch_q;
  assign fetch_address_o = out_addr_q;
  assign engine_halted_o = out_halted_q;
  assign buffer_done_o   = out_done_q;

`include "pcm_out_descriptor_dma_engine_macros.svh"

  `PCMDMA_ASSERT_IMP(a_no_fetch_no_addr, out_valid_q && !out_fetch_q, out_addr_q == '0, "address without fetch")
  `PCMDMA_ASSERT_IMP(a_refill_while_playing, left_mem_q, !halted_q && loaded_q && running_q, "refill while halted")
  `PCMDMA_ASSERT_IMP(a_index_in_ring, 1'b1, cur_q <= LastIdx && lvi_q <= LastIdx, "ring index out of range")
  `PCMDMA_ASSERT_NXT(a_chan_reset, chan_rst, halted_q && !running_q && !loaded_q && cur_q == '0, "channel reset incomplete")

endmodule

`default_nettype wire

// File: tb/pcm_out_descriptor_dma_engine_tb.sv
module pcm_out_descriptor_dma_engine_tb;
  import pcmdma_pkg::*;

  localparam int unsigned RING = 32;
  localparam int unsigned QUIET_LIMIT = 2000;
  localparam int unsigned PHASE_ITEMS = 250;
  localparam int unsigned LONG_HOLD = 300;

  typedef struct packed {
    opcode_e     op;
    logic [3:0]  ofs;
    logic [31:0] wdata;
    logic [4:0]  idx;
    logic [31:0] addr;
    logic [15:0] len;
  } bus_item_t;

  typedef struct packed {
    logic [31:0] read_data;
    logic        fetch_valid;
    logic [31:0] fetch_address;
    logic        engine_halted;
    logic        buffer_done;
  } engine_result_t;

  class dma_channel_checker;
    logic [31:0] base_reg;
    logic [4:0] cur_idx;
    logic [4:0] last_idx;
    logic [15:0] left;
    bit halted;
    bit running;
    bit loaded;
    logic [31:0] ent_addr [RING];
    logic [15:0] ent_len [RING];
    bit written [RING];
    engine_result_t pending_q [$];
    int unsigned fail_count;
    int unsigned results_seen;

    function new();
      clear_channel();
      foreach (written[i]) written[i] = 1'b0;
      fail_count = 0;
      results_seen = 0;
    endfunction

    function void clear_channel();
      base_reg = '0;
      cur_idx = '0;
      last_idx = '0;
      left = '0;
      halted = 1'b1;
      running = 1'b0;
      loaded = 1'b0;
    endfunction

    // ring entry that the next tick would read before it was ever loaded, or -1
    function int unready_entry();
      logic [4:0] c;
      logic [15:0] n;
      if (!running) return -1;
      c = cur_idx;
      n = left;
      if (halted) begin
        if (loaded) begin
          if (c == last_idx) return -1;
          c = c + 5'd1;
        end
        if (!written[c]) return int'(c);
        n = ent_len[c];
      end
      if (!written[c]) return int'(c);
      if (n != 0) n = n - 16'd1;
      if (n == 0 && c != last_idx) begin
        c = c + 5'd1;
        if (!written[c]) return int'(c);
      end
      return -1;
    endfunction

    function bit note_item(bus_item_t it);
      engine_result_t r;
      logic [31:0] span;
      bit acts;
      bit idle_tick;
      r = '0;
      acts = 1'b1;
      idle_tick = 1'b0;
      case (it.op)
        OpRead: begin
          case (it.ofs)
            OfsBase:   r.read_data = base_reg;
            OfsCur:    r.read_data = 32'(cur_idx);
            OfsLast:   r.read_data = 32'(last_idx);
            OfsStatus: r.read_data = 32'(halted);
            OfsLeft:   r.read_data = 32'(left);
            OfsCtrl:   r.read_data = 32'(running);
            default:   r.read_data = '0;
          endcase
        end
        OpWrite: begin
          case (it.ofs)
            OfsBase: base_reg = {it.wdata[31:3], 3'b000};
            OfsLast: last_idx = it.wdata[4:0];
            OfsCtrl: begin
              if (it.wdata[CtrlResetBit]) clear_channel();
              else running = it.wdata[CtrlRunBit];
            end
            default: acts = 1'b0;
          endcase
        end
        OpLoad: begin
          ent_addr[it.idx] = it.addr;
          ent_len[it.idx] = it.len;
          written[it.idx] = 1'b1;
        end
        default: begin
          if (running && halted) begin
            if (!loaded) begin
              left = ent_len[cur_idx];
              halted = 1'b0;
              loaded = 1'b1;
            end else if (cur_idx != last_idx) begin
              cur_idx = cur_idx + 5'd1;
              left = ent_len[cur_idx];
              halted = 1'b0;
              loaded = 1'b1;
            end else begin
              idle_tick = 1'b1;
            end
          end
          if (running && !idle_tick) begin
            if (left != 0) begin
              span = 32'(ent_len[cur_idx]) - 32'(left);
              r.fetch_valid = 1'b1;
              r.fetch_address = ent_addr[cur_idx] + (span << 1);
              left = left - 16'd1;
            end
            if (left == 0) begin
              r.buffer_done = 1'b1;
              if (cur_idx == last_idx) begin
                halted = 1'b1;
              end else begin
                cur_idx = cur_idx + 5'd1;
                left = ent_len[cur_idx];
              end
            end
          end
          acts = r.fetch_valid | r.buffer_done;
        end
      endcase
      r.engine_halted = halted;
      pending_q.push_back(r);
      return acts;
    endfunction

    function void check_field(string name, logic [31:0] exp_v, logic [31:0] got_v);
      if (got_v !== exp_v) begin
        $error("%s expected %h got %h", name, exp_v, got_v);
        fail_count++;
      end
    endfunction

    function void check_result(engine_result_t got);
      engine_result_t exp_r;
      results_seen++;
      if (pending_q.size() == 0) begin
        $error("result with no item outstanding");
        fail_count++;
        return;
      end
      exp_r = pending_q.pop_front();
      check_field("read_data", exp_r.read_data, got.read_data);
      check_field("fetch_valid", 32'(exp_r.fetch_valid), 32'(got.fetch_valid));
      check_field("fetch_address", exp_r.fetch_address, got.fetch_address);
      check_field("engine_halted", 32'(exp_r.engine_halted), 32'(got.engine_halted));
      check_field("buffer_done", 32'(exp_r.buffer_done), 32'(got.buffer_done));
    endfunction
  endclass

  logic        clk_i;
  logic        rst_ni;
  logic        in_valid_i;
  logic        in_stall_o;
  logic [1:0]  opcode_i;
  logic [3:0]  reg_offset_i;
  logic [31:0] write_data_i;
  logic [4:0]  desc_index_i;
  logic [31:0] desc_address_i;
  logic [15:0] desc_samples_i;
  logic        out_valid_o;
  logic        out_stall_i;
  logic [31:0] read_data_o;
  logic        fetch_valid_o;
  logic [31:0] fetch_address_o;
  logic        engine_halted_o;
  logic        buffer_done_o;

  dma_channel_checker chk;
  int unsigned idle_pct;
  int unsigned stall_pct;
  int unsigned quiet_cycles;
  bit long_hold_done;

  pcm_out_descriptor_dma_engine DUT (.*);

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  task automatic send_item(input bus_item_t it, output bit acts);
    in_valid_i <= 1'b1;
    opcode_i <= it.op;
    reg_offset_i <= it.ofs;
    write_data_i <= it.wdata;
    desc_index_i <= it.idx;
    desc_address_i <= it.addr;
    desc_samples_i <= it.len;
    do @(posedge clk_i); while (in_stall_o !== 1'b0);
    acts = chk.note_item(it);
  endtask

  task automatic bus_read(input logic [3:0] ofs);
    bit acts;
    send_item('{OpRead, ofs, 32'd0, 5'd0, 32'd0, 16'd0}, acts);
  endtask

  task automatic bus_write(input logic [3:0] ofs, input logic [31:0] d);
    bit acts;
    send_item('{OpWrite, ofs, d, 5'd0, 32'd0, 16'd0}, acts);
  endtask

  task automatic ring_load(input logic [4:0] i, input logic [31:0] a, input logic [15:0] n);
    bit acts;
    send_item('{OpLoad, 4'd0, 32'd0, i, a, n}, acts);
  endtask

  task automatic sample_tick();
    bit acts;
    send_item('{OpTick, 4'd0, 32'd0, 5'd0, 32'd0, 16'd0}, acts);
  endtask

  function automatic bus_item_t random_item();
    bus_item_t it;
    int unsigned pick;
    int unsigned sel;
    int miss;
    logic [3:0] mapped [6];
    mapped = '{OfsBase, OfsCur, OfsLast, OfsStatus, OfsLeft, OfsCtrl};
    it.ofs = 4'($urandom);
    it.wdata = $urandom;
    it.idx = 5'($urandom);
    it.addr = $urandom;
    it.len = 16'($urandom);
    pick = $urandom_range(99);
    if (chk.running && !chk.halted && chk.left > 40 && $urandom_range(19) == 0) begin
      // long buffer in play: cut it short with a channel reset
      it.op = OpWrite;
      it.ofs = OfsCtrl;
      it.wdata[CtrlResetBit] = 1'b1;
    end else if (pick < 50) begin
      it.op = OpTick;
    end else if (pick < 65) begin
      it.op = OpLoad;
      if ($urandom_range(4) != 0) it.idx = chk.cur_idx + 5'($urandom_range(0, 3));
      if ($urandom_range(19) != 0) it.len = 16'($urandom_range(0, 6));
    end else if (pick < 80) begin
      it.op = OpRead;
      if ($urandom_range(3) != 0) it.ofs = mapped[$urandom_range(0, 5)];
    end else begin
      it.op = OpWrite;
      sel = $urandom_range(9);
      if (sel < 4) begin
        it.ofs = OfsLast;
        it.wdata[4:0] = chk.cur_idx + 5'($urandom_range(chk.halted ? 1 : 0, 4));
      end else if (sel < 7) begin
        it.ofs = OfsCtrl;
        it.wdata[CtrlRunBit] = ($urandom_range(9) != 0);
        it.wdata[CtrlResetBit] = ($urandom_range(9) == 0);
      end else if (sel == 7) begin
        it.ofs = OfsBase;
      end
    end
    miss = chk.unready_entry();
    if (it.op == OpTick && miss >= 0) begin
      it.op = OpLoad;
      it.idx = 5'(miss);
      it.len = 16'($urandom_range(0, 6));
    end
    return it;
  endfunction

  // receiver side
  initial begin
    out_stall_i = 1'b0;
    long_hold_done = 1'b0;
    forever begin
      @(posedge clk_i);
      if (!long_hold_done && chk != null && chk.results_seen >= 100) begin
        long_hold_done = 1'b1;
        out_stall_i <= 1'b1;
        repeat (LONG_HOLD) @(posedge clk_i);
      end
      out_stall_i <= ($urandom_range(99) < stall_pct);
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni === 1'b1 && out_valid_o === 1'b1 && out_stall_i === 1'b0) begin
      chk.check_result({read_data_o, fetch_valid_o, fetch_address_o,
                        engine_halted_o, buffer_done_o});
    end
  end

  // watchdog on cycles with no handshake on either side
  always @(posedge clk_i) begin
    if ((in_valid_i === 1'b1 && in_stall_o === 1'b0) ||
        (out_valid_o === 1'b1 && out_stall_i === 1'b0)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
    end
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("FAIL pcm_out_descriptor_dma_engine");
      $finish;
    end
  end

  initial begin
    int unsigned idle_tab [4];
    int unsigned stall_tab [4];
    int unsigned done_items;
    bus_item_t it;
    bit acts;
    idle_tab = '{0, 45, 0, 38};
    stall_tab = '{0, 0, 45, 38};
    chk = new();
    idle_pct = 0;
    stall_pct = 0;
    quiet_cycles = 0;
    rst_ni = 1'b0;
    in_valid_i = 1'b0;
    opcode_i = '0;
    reg_offset_i = '0;
    write_data_i = '0;
    desc_index_i = '0;
    desc_address_i = '0;
    desc_samples_i = '0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // reset values, masking and ignored writes
    bus_read(OfsStatus);
    bus_read(4'hF);
    bus_write(OfsBase, 32'hFFFF_FFFF);
    bus_read(OfsBase);
    bus_write(OfsCur, 32'h0000_001F);
    bus_write(OfsLeft, 32'h0000_FFFF);
    ring_load(5'd0, 32'hFFFF_FFFC, 16'd3);
    ring_load(5'd1, 32'h0000_0000, 16'd0);
    ring_load(5'd2, 32'hFFFF_FFFE, 16'd2);
    ring_load(5'd31, 32'h1234_5678, 16'hFFFF);
    bus_write(OfsLast, 32'hFFFF_FFFF);
    bus_write(OfsLast, 32'h0000_0102);
    // paused tick, then start from a fresh ring
    sample_tick();
    bus_write(OfsCtrl, 32'h0000_0001);
    sample_tick();
    // rewrite the entry that is playing
    ring_load(5'd0, 32'h0000_0100, 16'd1);
    repeat (6) sample_tick();
    // restart after halting at the end of the list
    ring_load(5'd3, 32'h8000_0000, 16'd1);
    bus_write(OfsLast, 32'h0000_0003);
    sample_tick();
    // channel reset wins over run
    bus_write(OfsCtrl, 32'h0000_0003);
    bus_read(OfsCtrl);

    for (int ph = 0; ph < 4; ph++) begin
      idle_pct = idle_tab[ph];
      stall_pct = stall_tab[ph];
      done_items = 0;
      while (done_items < PHASE_ITEMS) begin
        it = random_item();
        send_item(it, acts);
        if (acts) done_items++;
        if (idle_pct != 0 && $urandom_range(99) < idle_pct) begin
          in_valid_i <= 1'b0;
          repeat ($urandom_range(1, 4)) @(posedge clk_i);
        end
      end
      in_valid_i <= 1'b0;
      while (chk.pending_q.size() != 0) @(posedge clk_i);
      @(posedge clk_i);
    end

    repeat (8) @(posedge clk_i);
    if (chk.fail_count == 0 && chk.pending_q.size() == 0) begin
      $display("PASS pcm_out_descriptor_dma_engine");
    end else begin
      $display("FAIL pcm_out_descriptor_dma_engine");
    end
    $finish;
  end

endmodule
